[src/tga_rle_scanline_decoder_defines.svh]
// ----------------------------------------------------------------------------
// TGA RLE scanline decoder assertion macros
// Clocked assertion helpers for the port checker file.
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_SCANLINE_DECODER_DEFINES_SVH
`define TGA_RLE_SCANLINE_DECODER_DEFINES_SVH

// Check on every clock edge outside reset.
`define TGA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every clock edge, reset included.
`define TGA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[src/tga_rle_pkg.sv]
// ----------------------------------------------------------------------------
// TGA RLE package
// Widths, codes, queue entry and configuration types for the decoder.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

   localparam int BYTE_W      = 8;
   localparam int COL_W       = 16;
   localparam int LEN_W       = 8;
   localparam int IDX_W       = 16;
   localparam int CH_W        = 8;
   localparam int FMT_W       = 3;
   localparam int BIP_W       = 2;
   localparam int PIX_W       = 4 * BYTE_W;
   localparam int PBYTES_W    = 3 * BYTE_W;
   localparam int CSR_W       = 16;
   localparam int CSR_IDX_W   = 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Packet header layout.
   localparam logic [BYTE_W-1:0] HDR_COUNT_MASK = 8'h7f;
   localparam logic [BYTE_W-1:0] HDR_REPEAT_BIT = 8'h80;
   localparam int                RGB5_MAX       = 31;
   localparam int                RGB5_SHIFT     = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_WIDTH   = 2'd0,
      CSR_RUN_LENGTH   = 2'd1,
      CSR_PIXEL_FORMAT = 2'd2
   } csr_index_type;

   typedef enum logic [FMT_W-1:0] {
      FMT_INDEX8  = 3'd0,
      FMT_INDEX16 = 3'd1,
      FMT_RGB555  = 3'd2,
      FMT_BGR24   = 3'd3,
      FMT_BGRA32  = 3'd4
   } pixel_format_type;

   typedef struct packed {
      logic [COL_W-1:0] line_width;
      logic             run_length_coded;
      logic [FMT_W-1:0] pixel_format;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0] x_start;
      logic [LEN_W-1:0] span_length;
      logic             end_of_line;
      logic [FMT_W-1:0] pixel_format;
      logic [PIX_W-1:0] pixel;
   } span_cmd_type;

   function automatic logic [FMT_W-1:0] bytes_per_pixel(input logic [FMT_W-1:0] fmt);
      logic [FMT_W-1:0] bpp;
      case (fmt)
         FMT_INDEX16: bpp = 3'd2;
         FMT_RGB555:  bpp = 3'd2;
         FMT_BGR24:   bpp = 3'd3;
         FMT_BGRA32:  bpp = 3'd4;
         default:     bpp = 3'd1;
      endcase
      return bpp;
   endfunction

endpackage

[src/tga_rle_ifs.sv]
// ----------------------------------------------------------------------------
// TGA RLE stream interfaces
// Valid/ready channels for the byte stream and the decoded span stream.
// ----------------------------------------------------------------------------
interface tga_rle_req_if;
   import tga_rle_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface tga_rle_rsp_if;
   import tga_rle_pkg::*;

   logic             valid;
   logic             ready;
   logic [COL_W-1:0] x_start;
   logic [LEN_W-1:0] span_length;
   logic [IDX_W-1:0] index_value;
   logic [CH_W-1:0]  red;
   logic [CH_W-1:0]  green;
   logic [CH_W-1:0]  blue;
   logic [CH_W-1:0]  alpha;
   logic             end_of_line;

   modport source (output valid, output x_start, output span_length, output index_value,
                   output red, output green, output blue, output alpha,
                   output end_of_line, input ready);
   modport sink   (input valid, input x_start, input span_length, input index_value,
                   input red, input green, input blue, input alpha,
                   input end_of_line, output ready);
endinterface

[src/tga_rle_scanline_decoder.sv]
// ----------------------------------------------------------------------------
// TGA RLE scanline decoder
// Turns a Targa image byte stream (plain or RLE packets) into pixel spans.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake       payload
//   --------  ---------  --------------  ----------------------------------------
//   req_if    in         valid / ready   data_byte
//   rsp_if    out        valid / ready   x_start, span_length, index_value,
//                                        red, green, blue, alpha, end_of_line
//   csr_*     in         csr_we          csr_index, csr_wdata
//
// One byte is accepted per cycle while the span queue has room. A span passes
// through the span queue and then the output register after the byte that
// completes its pixel. The front end's column and packet update is the loop
// that sets the byte rate. Reset is synchronous and active high; it restores
// line_width 1, plain coding and the 8-bit index format. A stalled rsp_if fills
// the two-entry queue and then drops req_if.ready; headers and partial pixels
// still pass only while the queue has room.
//
module tga_rle_scanline_decoder (
   input  logic                              clock,
   input  logic                              reset,
   tga_rle_req_if.sink                       req_if,
   tga_rle_rsp_if.source                     rsp_if,
   input  logic                              csr_we,
   input  logic [tga_rle_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tga_rle_pkg::CSR_W-1:0]     csr_wdata
);
   import tga_rle_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         q_full;
   logic         q_not_empty;
   logic         accept;
   logic         push;
   logic         pop;
   span_cmd_type push_cmd;
   span_cmd_type head_cmd;

   // Configuration: the user must write only while the block is idle; the block itself does not enforce it.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LINE_WIDTH:   cfg_in.line_width       = csr_wdata;
            CSR_RUN_LENGTH:   cfg_in.run_length_coded = csr_wdata[0];
            CSR_PIXEL_FORMAT: cfg_in.pixel_format     = csr_wdata[FMT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_width       <= COL_W'(1);
         cfg_ff.run_length_coded <= 1'b0;
         cfg_ff.pixel_format     <= FMT_INDEX8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Hold the byte stream whenever the queue cannot take another span.
   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && !q_full;

   tga_rle_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .data_byte (req_if.data_byte),
      .push      (push),
      .cmd       (push_cmd)
   );

   tga_rle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   tga_rle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_not_empty),
      .cmd       (head_cmd),
      .pop       (pop),
      .rsp       (rsp_if)
   );

endmodule

[src/tga_rle_queue.sv]
// ----------------------------------------------------------------------------
// TGA RLE span queue
// Small FIFO of span commands between the byte front end and the span back end.
// ----------------------------------------------------------------------------
module tga_rle_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tga_rle_pkg::span_cmd_type push_cmd,
   output logic                      full,
   input  logic                      pop,
   output logic                      not_empty,
   output tga_rle_pkg::span_cmd_type head_cmd
);
   import tga_rle_pkg::*;

   span_cmd_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[src/tga_rle_front.sv]
// ----------------------------------------------------------------------------
// TGA RLE front end
// Classifies each byte as header or pixel data, tracks packets and columns.
// ----------------------------------------------------------------------------
module tga_rle_front (
   input  logic                             clock,
   input  logic                             reset,
   input  tga_rle_pkg::cfg_type             cfg,
   input  logic                             accept,
   input  logic [tga_rle_pkg::BYTE_W-1:0]   data_byte,
   output logic                             push,
   output tga_rle_pkg::span_cmd_type        cmd
);
   import tga_rle_pkg::*;

   logic [COL_W-1:0]    col_ff, col_in;
   logic [LEN_W-1:0]    left_ff, left_in;
   logic                repeat_ff, repeat_in;
   logic                await_ff, await_in;
   logic [BIP_W-1:0]    bip_ff, bip_in;
   logic [PBYTES_W-1:0] pbytes_ff, pbytes_in;

   logic [COL_W-1:0]    width;
   logic [COL_W-1:0]    col;
   logic [COL_W-1:0]    rem;
   logic [FMT_W-1:0]    bpp;
   logic [FMT_W-1:0]    bip_next;
   logic                complete;
   logic [PIX_W-1:0]    pix;
   logic [PBYTES_W-1:0] pbytes_store;
   logic [LEN_W-1:0]    hdr_count;
   logic [LEN_W-1:0]    hdr_left;
   logic [LEN_W-1:0]    left;
   logic [LEN_W-1:0]    left_dec;
   logic [LEN_W-1:0]    rep_len;
   logic [LEN_W-1:0]    len;
   logic [COL_W:0]      col_sum;
   logic                eol;
   logic [COL_W-1:0]    col_after;

   always_comb begin
      width    = (cfg.line_width == '0) ? COL_W'(1) : cfg.line_width;
      col      = (col_ff < width) ? col_ff : '0;
      rem      = width - col;
      bpp      = bytes_per_pixel(cfg.pixel_format);
      bip_next = {1'b0, bip_ff} + 3'd1;
      complete = (bip_next >= bpp);

      // Last byte lands in the slot of the format's final byte.
      pix = {{BYTE_W{1'b0}}, pbytes_ff};
      case (bpp)
         3'd1:    pix[7:0]   = data_byte;
         3'd2:    pix[15:8]  = data_byte;
         3'd3:    pix[23:16] = data_byte;
         default: pix[31:24] = data_byte;
      endcase

      pbytes_store = pbytes_ff;
      case (bip_ff)
         2'd0:    pbytes_store[7:0]   = data_byte;
         2'd1:    pbytes_store[15:8]  = data_byte;
         default: pbytes_store[23:16] = data_byte;
      endcase

      hdr_count = (data_byte & HDR_COUNT_MASK) + 8'd1;
      hdr_left  = ({8'd0, hdr_count} < rem) ? hdr_count : rem[LEN_W-1:0];
      left      = (left_ff == '0) ? 8'd1 : left_ff;
      left_dec  = left - 8'd1;
      rep_len   = ({8'd0, left} < rem) ? left : rem[LEN_W-1:0];
      len       = (cfg.run_length_coded && repeat_ff) ? rep_len : 8'd1;
      col_sum   = {1'b0, col} + {{(COL_W + 1 - LEN_W){1'b0}}, len};
      eol       = (col_sum >= {1'b0, width});
      col_after = eol ? '0 : col_sum[COL_W-1:0];

      col_in    = col_ff;
      left_in   = left_ff;
      repeat_in = repeat_ff;
      await_in  = await_ff;
      bip_in    = bip_ff;
      pbytes_in = pbytes_ff;
      push      = 1'b0;

      if (accept) begin
         if (!cfg.run_length_coded) begin
            // Plain stream: packet state holds untouched.
            if (!complete) begin
               pbytes_in = pbytes_store;
               bip_in    = bip_next[BIP_W-1:0];
            end else begin
               push   = 1'b1;
               col_in = col_after;
               bip_in = '0;
            end
         end else if (await_ff) begin
            col_in    = col;
            left_in   = hdr_left;
            repeat_in = ((data_byte & HDR_REPEAT_BIT) != '0);
            await_in  = 1'b0;
            bip_in    = '0;
         end else if (!complete) begin
            pbytes_in = pbytes_store;
            bip_in    = bip_next[BIP_W-1:0];
         end else begin
            push   = 1'b1;
            col_in = col_after;
            bip_in = '0;
            if (repeat_ff || left_dec == '0 || eol) begin
               left_in  = '0;
               await_in = 1'b1;
            end else begin
               left_in = left_dec;
            end
         end
      end

      cmd.x_start      = col;
      cmd.span_length  = len;
      cmd.end_of_line  = eol;
      cmd.pixel_format = cfg.pixel_format;
      cmd.pixel        = pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         left_ff   <= '0;
         repeat_ff <= 1'b0;
         await_ff  <= 1'b1;
         bip_ff    <= '0;
         pbytes_ff <= '0;
      end else begin
         col_ff    <= col_in;
         left_ff   <= left_in;
         repeat_ff <= repeat_in;
         await_ff  <= await_in;
         bip_ff    <= bip_in;
         pbytes_ff <= pbytes_in;
      end
   end

endmodule

[src/tga_rle_back.sv]
// ----------------------------------------------------------------------------
// TGA RLE back end
// Decodes queued span commands into channel values and holds the result.
// ----------------------------------------------------------------------------
module tga_rle_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  tga_rle_pkg::span_cmd_type cmd,
   output logic                      pop,
   tga_rle_rsp_if.source             rsp
);
   import tga_rle_pkg::*;

   logic             valid_ff;
   logic [COL_W-1:0] x_start_ff;
   logic [LEN_W-1:0] length_ff;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [CH_W-1:0]  red_ff, red_in;
   logic [CH_W-1:0]  green_ff, green_in;
   logic [CH_W-1:0]  blue_ff, blue_in;
   logic [CH_W-1:0]  alpha_ff, alpha_in;
   logic             eol_ff;

   logic [CH_W-1:0]  b0, b1, b2, b3;
   logic [IDX_W-1:0] word;

   assign pop = cmd_valid && (!valid_ff || rsp.ready);

   always_comb begin
      b0   = cmd.pixel[7:0];
      b1   = cmd.pixel[15:8];
      b2   = cmd.pixel[23:16];
      b3   = cmd.pixel[31:24];
      word = {b1, b0};

      index_in = '0;
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      alpha_in = '0;
      case (cmd.pixel_format)
         FMT_INDEX16: index_in = word;
         FMT_RGB555: begin
            red_in   = CH_W'(word[14:10] & 5'(RGB5_MAX)) << RGB5_SHIFT;
            green_in = CH_W'(word[9:5]   & 5'(RGB5_MAX)) << RGB5_SHIFT;
            blue_in  = CH_W'(word[4:0]   & 5'(RGB5_MAX)) << RGB5_SHIFT;
         end
         FMT_BGR24: begin
            red_in   = b2;
            green_in = b1;
            blue_in  = b0;
         end
         FMT_BGRA32: begin
            red_in   = b2;
            green_in = b1;
            blue_in  = b0;
            alpha_in = b3;
         end
         default: index_in = {{(IDX_W - CH_W){1'b0}}, b0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         x_start_ff <= cmd.x_start;
         length_ff  <= cmd.span_length;
         index_ff   <= index_in;
         red_ff     <= red_in;
         green_ff   <= green_in;
         blue_ff    <= blue_in;
         alpha_ff   <= alpha_in;
         eol_ff     <= cmd.end_of_line;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.x_start     = x_start_ff;
   assign rsp.span_length = length_ff;
   assign rsp.index_value = index_ff;
   assign rsp.red         = red_ff;
   assign rsp.green       = green_ff;
   assign rsp.blue        = blue_ff;
   assign rsp.alpha       = alpha_ff;
   assign rsp.end_of_line = eol_ff;

endmodule

[src/tga_rle_sva.sv]
// ----------------------------------------------------------------------------
// TGA RLE port checker
// Concurrent checks on the decoder's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "tga_rle_scanline_decoder_defines.svh"

module tga_rle_sva (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tga_rle_pkg::LEN_W-1:0] span_length,
   input logic [tga_rle_pkg::IDX_W-1:0] index_value,
   input logic [tga_rle_pkg::CH_W-1:0]  red,
   input logic [tga_rle_pkg::CH_W-1:0]  green,
   input logic [tga_rle_pkg::CH_W-1:0]  blue,
   input logic [tga_rle_pkg::CH_W-1:0]  alpha
);
   import tga_rle_pkg::*;

   logic len_ok;
   logic color_zero;

   assign len_ok     = (span_length != '0) && (span_length <= 8'd128);
   assign color_zero = (red == '0) && (green == '0) && (blue == '0) && (alpha == '0);

   `TGA_ASSERT_ALWAYS(a_idle_after_reset, reset |=> !rsp_valid, "span valid after reset")
   `TGA_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "span dropped while stalled")
   `TGA_ASSERT(a_len_range, rsp_valid |-> len_ok, "span length out of range")
   `TGA_ASSERT(a_index_excl, rsp_valid && index_value != '0 |-> color_zero, "index with color set")

endmodule

bind tga_rle_scanline_decoder tga_rle_sva u_sva (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .span_length (rsp_if.span_length),
   .index_value (rsp_if.index_value),
   .red         (rsp_if.red),
   .green       (rsp_if.green),
   .blue        (rsp_if.blue),
   .alpha       (rsp_if.alpha)
);
